// ===== rtl/tfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfdc_pkg
// Shared types and constants of the thermal fan duty controller.
// ----------------------------------------------------------------------------
package tfdc_pkg;

    localparam int unsigned TEMP_W   = 8;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned EXCESS_W = TEMP_W + 1;
    localparam int unsigned STEP_W   = 6;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned DUTY_MAX   = 255;
    localparam int unsigned DUTY_STEPS = 7;
    localparam int          HYST_DEG   = 2;

    // floor(x / 7) for x below 256 is (x * 293) >> 11
    localparam int unsigned RECIP7_MUL   = 293;
    localparam int unsigned RECIP7_SHIFT = 11;

    localparam logic [DUTY_W-1:0]          BASE_DUTY_RST = 8'd64;
    localparam logic [TEMP_W-1:0]          LIMIT1_RST    = 8'd50;
    localparam logic [TEMP_W-1:0]          LIMIT2_RST    = 8'd70;
    localparam logic                       TWO_FANS_RST  = 1'b1;
    localparam logic signed [EXCESS_W-1:0] EXCESS_RST    = -9'sd80;
    localparam logic [DUTY_W-1:0]          DUTY_RST      = 8'd0;
    localparam logic [STEP_W-1:0]          STEP_RST      =
        STEP_W'((DUTY_MAX - 64) / DUTY_STEPS);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DUTY = 2'd0,
        CFG_LIMIT1    = 2'd1,
        CFG_LIMIT2    = 2'd2,
        CFG_TWO_FANS  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DUTY_W-1:0] base_duty;
        logic [STEP_W-1:0] duty_step;
        logic [TEMP_W-1:0] limit1;
        logic [TEMP_W-1:0] limit2;
        logic              two_fans;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] fan1_duty;
        logic              fan1_update;
        logic [DUTY_W-1:0] fan0_duty;
        logic              fan0_update;
    } t_result;

endpackage

// ===== rtl/tfdc_cfg.sv =====
// ----------------------------------------------------------------------------
// tfdc_cfg
// Configuration registers; derives the duty step when the base duty is written.
// ----------------------------------------------------------------------------
module tfdc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tfdc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [tfdc_pkg::CFG_W-1:0]       i_cfg_data,
    output tfdc_pkg::t_cfg                   o_cfg
);

    tfdc_pkg::t_cfg r_cfg;
    logic [tfdc_pkg::DUTY_W-1:0] headroom;
    logic [16:0]                 step_prod;
    logic [tfdc_pkg::STEP_W-1:0] n_step;

    // Step = (255 - base) / 7 through a reciprocal multiply
    assign headroom  = 8'(tfdc_pkg::DUTY_MAX) - i_cfg_data;
    assign step_prod = 17'(headroom) * 17'(tfdc_pkg::RECIP7_MUL);
    assign n_step    = step_prod[tfdc_pkg::RECIP7_SHIFT +: tfdc_pkg::STEP_W];

    // Write one register per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_duty <= tfdc_pkg::BASE_DUTY_RST;
            r_cfg.duty_step <= tfdc_pkg::STEP_RST;
            r_cfg.limit1    <= tfdc_pkg::LIMIT1_RST;
            r_cfg.limit2    <= tfdc_pkg::LIMIT2_RST;
            r_cfg.two_fans  <= tfdc_pkg::TWO_FANS_RST;
        end else if (i_cfg_we) begin
            unique case (tfdc_pkg::t_cfg_reg'(i_cfg_addr))
                tfdc_pkg::CFG_BASE_DUTY: begin
                    r_cfg.base_duty <= i_cfg_data;
                    r_cfg.duty_step <= n_step;
                end
                tfdc_pkg::CFG_LIMIT1:   r_cfg.limit1   <= i_cfg_data;
                tfdc_pkg::CFG_LIMIT2:   r_cfg.limit2   <= i_cfg_data;
                tfdc_pkg::CFG_TWO_FANS: r_cfg.two_fans <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/tfdc_eval.sv =====
// ----------------------------------------------------------------------------
// tfdc_eval
// Per-tick decision: hysteresis test, duty computation, fan state update.
// ----------------------------------------------------------------------------
module tfdc_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [tfdc_pkg::TEMP_W-1:0]   i_temp1,
    input  logic [tfdc_pkg::TEMP_W-1:0]   i_temp2,
    input  tfdc_pkg::t_cfg                i_cfg,
    output tfdc_pkg::t_result             o_res
);

    localparam int EW = tfdc_pkg::EXCESS_W;

    logic signed [EW-1:0]           r_last_excess [2];
    logic [tfdc_pkg::DUTY_W-1:0]    r_last_duty [2];

    logic signed [EW-1:0]           ex1, ex2, ex_sel;
    logic signed [EW:0]             diff1, diff2;
    logic                           near1, near2;
    logic                           hit1, hit2, stop, write;
    logic [tfdc_pkg::TEMP_W-1:0]    ex_m1;
    logic [13:0]                    prod;
    logic [14:0]                    sum;
    logic [tfdc_pkg::DUTY_W-1:0]    calc_duty, new_duty;

    // Excess over each limit
    assign ex1 = $signed({1'b0, i_temp1}) - $signed({1'b0, i_cfg.limit1});
    assign ex2 = $signed({1'b0, i_temp2}) - $signed({1'b0, i_cfg.limit2});

    // Hysteresis against the stored excess of each sensor's slot
    assign diff1 = {ex1[EW-1], ex1} - {r_last_excess[0][EW-1], r_last_excess[0]};
    assign diff2 = {ex2[EW-1], ex2}
                 - {r_last_excess[i_cfg.two_fans][EW-1], r_last_excess[i_cfg.two_fans]};
    assign near1 = (diff1 > -(EW+1)'(tfdc_pkg::HYST_DEG))
                && (diff1 < (EW+1)'(tfdc_pkg::HYST_DEG));
    assign near2 = (diff2 > -(EW+1)'(tfdc_pkg::HYST_DEG))
                && (diff2 < (EW+1)'(tfdc_pkg::HYST_DEG));

    // Sensor one wins; stop needs sensor one at least two below and sensor two three below
    assign hit1  = !ex1[EW-1] && !near1;
    assign hit2  = !hit1 && !ex2[EW-1] && !near2;
    assign stop  = (ex1 < -EW'(1)) && (ex2 < -EW'(2));
    assign write = hit1 || hit2 || stop;

    // Duty = base + (excess - 1) * step, clamped to [base, 255]
    assign ex_sel = hit1 ? ex1 : ex2;
    assign ex_m1  = ex_sel[tfdc_pkg::TEMP_W-1:0] - 8'd1;
    assign prod   = 14'(ex_m1) * 14'(i_cfg.duty_step);
    assign sum    = 15'(i_cfg.base_duty) + 15'(prod);

    always_comb begin
        priority if (ex_sel == '0) begin
            calc_duty = i_cfg.base_duty;
        end else if (sum > 15'(tfdc_pkg::DUTY_MAX)) begin
            calc_duty = 8'(tfdc_pkg::DUTY_MAX);
        end else begin
            calc_duty = sum[tfdc_pkg::DUTY_W-1:0];
        end
    end

    assign new_duty = stop ? '0 : calc_duty;

    // Result fields: report a fan only when its duty changes
    always_comb begin
        o_res.fan0_update = write && (new_duty != r_last_duty[0]);
        o_res.fan0_duty   = write ? new_duty : r_last_duty[0];
        o_res.fan1_update = write && i_cfg.two_fans && (new_duty != r_last_duty[1]);
        o_res.fan1_duty   = (write && i_cfg.two_fans) ? new_duty : r_last_duty[1];
    end

    // Advance the hysteresis and duty state once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_excess[0] <= tfdc_pkg::EXCESS_RST;
            r_last_excess[1] <= tfdc_pkg::EXCESS_RST;
            r_last_duty[0]   <= tfdc_pkg::DUTY_RST;
            r_last_duty[1]   <= tfdc_pkg::DUTY_RST;
        end else if (i_fire) begin
            if (hit1) begin
                r_last_excess[0] <= ex1;
            end else if (hit2) begin
                r_last_excess[i_cfg.two_fans] <= ex2;
            end
            r_last_duty[0] <= o_res.fan0_duty;
            r_last_duty[1] <= o_res.fan1_duty;
        end
    end

`ifndef SYNTHESIS
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> $onehot0({hit1, hit2, stop}))
        else $error("more than one duty action in a tick");

    a_single_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_cfg.two_fans |-> !o_res.fan1_update)
        else $error("fan one updated in single-fan mode");

    a_update_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.fan0_update |=> r_last_duty[0] != $past(r_last_duty[0]))
        else $error("fan zero update without a duty change");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && stop |=> r_last_duty[0] == '0)
        else $error("stop did not clear fan zero duty");
`endif

endmodule

// ===== rtl/thermal_fan_duty_controller_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_fan_duty_controller_unit
// Thermal fan duty controller: two temperatures in, two fan duties out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_t*) takes one tick per transaction: both sensor
//   temperatures. Master channel (m_t*) returns exactly one result per tick:
//   update flag and duty for each fan. Configuration registers are written
//   through i_cfg_we / i_cfg_addr / i_cfg_data, one register per cycle. The
//   user must write them only while no tick is in flight; it is not enforced.
// Timing:
//   A tick accepted into the input register is evaluated in one pass against
//   the stored excess and duty state when the stage advances, and its result
//   is captured in the result register. One tick per cycle is sustained while
//   m_tready stays high; the single evaluation stage, which updates the fan
//   state as it produces the result, sets this figure.
// Reset:
//   Registers return to base 64, limits 50 and 70, two-fan mode; stored
//   excess is -80 in both slots and both duties are 0.
// Stall:
//   While m_tready is low the result is held; the input register still
//   fills, then s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module thermal_fan_duty_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] temp_sensor1, [15:8] temp_sensor2
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] fan0_update, [8:1] fan0_duty,
                                   // [9] fan1_update, [17:10] fan1_duty, rest 0
);

    tfdc_pkg::t_cfg    cfg;
    tfdc_pkg::t_result res;

    logic                        r_in_valid;
    logic [tfdc_pkg::TEMP_W-1:0] r_temp1, r_temp2;
    logic                        r_out_valid;
    tfdc_pkg::t_result           r_out;
    logic                        advance, fire;

    tfdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move the evaluation stage whenever the result register is free or drains
    assign advance  = !r_out_valid || m_tready;
    assign fire     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_temp1 <= s_tdata[7:0];
            r_temp2 <= s_tdata[15:8];
        end
    end

    tfdc_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_temp1 (r_temp1),
        .i_temp2 (r_temp2),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out};

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermal fan duty controller. Ticks of two
// temperatures are fed through the slave stream from a queue, with random gaps,
// and every result on the master stream is checked field by field against a
// local model of the duty and hysteresis rules. Several register settings are
// visited, the extremes among them, and one long receiver hold-off backs the
// block up so that its input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int TICKS_PER_PHASE = 180;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata    = '0;   // [7:0] temp_sensor1, [15:8] temp_sensor2
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [23:0] m_tdata;           // [0] fan0_update, [8:1] fan0_duty,
                                    // [9] fan1_update, [17:10] fan1_duty

    thermal_fan_duty_controller_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Model of the fan controller: settings, stored excess and duty per slot
    logic [7:0] cfg_base = tfdc_pkg::BASE_DUTY_RST;
    logic [7:0] cfg_lim1 = tfdc_pkg::LIMIT1_RST;
    logic [7:0] cfg_lim2 = tfdc_pkg::LIMIT2_RST;
    logic       cfg_two  = tfdc_pkg::TWO_FANS_RST;
    int         fan_excess[2] = '{tfdc_pkg::EXCESS_RST, tfdc_pkg::EXCESS_RST};
    logic [7:0] fan_duty[2]   = '{tfdc_pkg::DUTY_RST, tfdc_pkg::DUTY_RST};
    bit         fan_changed[2];

    logic [15:0]       tick_q[$];
    tfdc_pkg::t_result fan_expect_q[$];

    int  fail_count  = 0;
    int  quiet_count = 0;
    bit  tick_taken  = 1'b0;
    bit  calm        = 1'b0;
    int  send_gap    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    int  holds_asked = 0;
    int  holds_done  = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Write a duty to both fans; fan one is left alone in single-fan mode
    function automatic void command_fans(int duty);
        for (int f = 0; f < 2; f++) begin
            if (f == 0 || cfg_two) begin
                if (fan_duty[f] != 8'(duty)) begin
                    fan_duty[f]    = 8'(duty);
                    fan_changed[f] = 1'b1;
                end
            end
        end
    endfunction

    // Evaluate one tick: sensor one first, then sensor two
    function automatic tfdc_pkg::t_result advance_fans(logic [7:0] t1, logic [7:0] t2);
        int                prev_ex;
        int                ex;
        int                slot;
        int                step;
        int                duty;
        int                diff;
        bit                done;
        tfdc_pkg::t_result r;
        prev_ex        = 0;
        done           = 1'b0;
        fan_changed[0] = 1'b0;
        fan_changed[1] = 1'b0;
        for (int s = 0; s < 2; s++) begin
            if (!done) begin
                ex   = (s == 0) ? int'(t1) - int'(cfg_lim1) : int'(t2) - int'(cfg_lim2);
                slot = (cfg_two && s == 1) ? 1 : 0;
                if (ex >= 0) begin
                    diff = ex - fan_excess[slot];
                    // within the hysteresis band: skip, previous excess stays
                    if (diff >= tfdc_pkg::HYST_DEG || diff <= -tfdc_pkg::HYST_DEG) begin
                        step = (int'(tfdc_pkg::DUTY_MAX) - int'(cfg_base))
                             / int'(tfdc_pkg::DUTY_STEPS);
                        duty = int'(cfg_base) + (ex - 1) * step;
                        if (duty < int'(cfg_base))
                            duty = int'(cfg_base);
                        if (duty > int'(tfdc_pkg::DUTY_MAX))
                            duty = int'(tfdc_pkg::DUTY_MAX);
                        command_fans(duty);
                        fan_excess[slot] = ex;
                        done = 1'b1;
                    end
                end else begin
                    // stop the fans only when sensor one was cold as well
                    if (ex < -2 && s == 1 && prev_ex < -1)
                        command_fans(0);
                    prev_ex = ex;
                end
            end
        end
        r.fan0_update = fan_changed[0];
        r.fan0_duty   = fan_duty[0];
        r.fan1_update = fan_changed[1];
        r.fan1_duty   = fan_duty[1];
        return r;
    endfunction

    // Write one register and keep the model in step
    task automatic write_reg(tfdc_pkg::t_cfg_reg idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            tfdc_pkg::CFG_BASE_DUTY: cfg_base = val;
            tfdc_pkg::CFG_LIMIT1:    cfg_lim1 = val;
            tfdc_pkg::CFG_LIMIT2:    cfg_lim2 = val;
            tfdc_pkg::CFG_TWO_FANS:  cfg_two  = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [7:0] base, logic [7:0] lim1, logic [7:0] lim2,
                             logic two);
        write_reg(tfdc_pkg::CFG_BASE_DUTY, base);
        write_reg(tfdc_pkg::CFG_LIMIT1, lim1);
        write_reg(tfdc_pkg::CFG_LIMIT2, lim2);
        write_reg(tfdc_pkg::CFG_TWO_FANS, {7'd0, two});
    endtask

    task automatic push_tick(int t1, int t2);
        tick_q.push_back({8'(t2), 8'(t1)});
    endtask

    // Hold until every tick is sent and every result has come back
    task automatic drain();
        while (tick_q.size() != 0 || s_tvalid || fan_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Sender: offer the next tick once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tick_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                s_tdata  <= tick_q.pop_front();
                s_tvalid <= 1'b1;
                send_gap = calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            hold_left  = LONG_HOLD;
            holds_done = holds_asked;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = calm ? 0 : pick_gap();
        end
    end

    // Monitor: predict on each accepted tick, check each accepted result
    always @(posedge i_clk) begin
        tfdc_pkg::t_result got;
        tfdc_pkg::t_result want;
        tick_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready)
            fan_expect_q.push_back(advance_fans(s_tdata[7:0], s_tdata[15:8]));
        if (i_rst_n && m_tvalid && m_tready) begin
            got = tfdc_pkg::t_result'(m_tdata[17:0]);
            if (fan_expect_q.size() == 0) begin
                $error("unexpected result transaction: %h", m_tdata);
                fail_count++;
            end else begin
                want = fan_expect_q.pop_front();
                if (got.fan0_update !== want.fan0_update) begin
                    $error("fan0_update: expected %0d, got %0d",
                           want.fan0_update, got.fan0_update);
                    fail_count++;
                end
                if (got.fan0_duty !== want.fan0_duty) begin
                    $error("fan0_duty: expected %0d, got %0d",
                           want.fan0_duty, got.fan0_duty);
                    fail_count++;
                end
                if (got.fan1_update !== want.fan1_update) begin
                    $error("fan1_update: expected %0d, got %0d",
                           want.fan1_update, got.fan1_update);
                    fail_count++;
                end
                if (got.fan1_duty !== want.fan1_duty) begin
                    $error("fan1_duty: expected %0d, got %0d",
                           want.fan1_duty, got.fan1_duty);
                    fail_count++;
                end
                if (m_tdata[23:18] !== 6'd0) begin
                    $error("padding: expected 0, got %0d", m_tdata[23:18]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort when nothing moves on either stream for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count = 0;
        else
            quiet_count = quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int w1;
        int w2;
        int r;
        logic [7:0] base;
        logic [7:0] lim1;
        logic [7:0] lim2;
        logic       two;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: clamp at base, hysteresis, stop test, mild cold
        push_tick(0, 0);       // stop with fans already stopped
        push_tick(50, 0);      // zero excess clamps up to base
        push_tick(51, 0);      // hysteresis skip blocks the stop
        push_tick(52, 0);
        push_tick(255, 255);   // clamp at full scale
        push_tick(0, 255);     // same duty again, no update
        push_tick(49, 70);     // mild cold on sensor one, sensor two drives
        push_tick(49, 0);      // mild cold blocks the stop
        push_tick(48, 0);      // cold sensor one lets sensor two stop
        push_tick(0, 68);      // mild cold on sensor two
        push_tick(60, 0);
        push_tick(0, 67);      // stop
        drain();

        // Single fan, lowest base and limits at both ends
        write_all(8'd0, 8'd0, 8'd255, 1'b0);
        push_tick(0, 0);
        push_tick(1, 255);
        push_tick(2, 255);
        push_tick(255, 0);
        push_tick(100, 255);
        push_tick(0, 252);     // sensor one at zero excess drives fan zero to base
        drain();

        // Highest base: zero step, duty pinned at full scale
        write_all(8'd255, 8'd255, 8'd0, 1'b1);
        push_tick(255, 0);
        push_tick(254, 0);
        push_tick(0, 0);
        push_tick(0, 255);
        push_tick(255, 255);
        drain();

        // Random phases: temperatures wander around the limits
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin base = 8'd64;  lim1 = 8'd50;  lim2 = 8'd70;  two = 1'b1; end
                1: begin base = 8'd0;   lim1 = 8'd0;   lim2 = 8'd255; two = 1'b1; end
                2: begin base = 8'd255; lim1 = 8'd255; lim2 = 8'd0;   two = 1'b0; end
                default: begin
                    base = 8'($urandom_range(0, 255));
                    lim1 = 8'($urandom_range(0, 255));
                    lim2 = 8'($urandom_range(0, 255));
                    two  = p[0];
                end
            endcase
            write_all(base, lim1, lim2, two);
            calm = (p == 3 || p == 6);
            if (p == 1)
                holds_asked = holds_asked + 1;
            w1 = int'(lim1);
            w2 = int'(lim2);
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    w1 = $urandom_range(0, 255);
                else
                    w1 = w1 + $urandom_range(0, 8) - 4;
                r = $urandom_range(0, 99);
                if (r < 8)
                    w2 = $urandom_range(0, 255);
                else
                    w2 = w2 + $urandom_range(0, 8) - 4;
                w1 = (w1 < 0) ? 0 : (w1 > 255) ? 255 : w1;
                w2 = (w2 < 0) ? 0 : (w2 > 255) ? 255 : w2;
                push_tick(w1, w2);
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && fan_expect_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tfdc_pkg.sv
rtl/tfdc_cfg.sv
rtl/tfdc_eval.sv
rtl/thermal_fan_duty_controller_unit.sv
test/tb_top.sv
